/* sv/led_slot_pattern_blinker_top_macros.svh */
// assertion macros used by the led slot-pattern blinker core
// expects clk and arst_n in the scope of each use
`ifndef LED_SLOT_PATTERN_BLINKER_TOP_MACROS_SVH
`define LED_SLOT_PATTERN_BLINKER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define LSPB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define LSPB_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`define LSPB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define LSPB_ASSERT(lbl, prop, msg)
`define LSPB_ASSERT_IMPL(lbl, ante, cons, msg)
`define LSPB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* sv/lspb_pkg.sv */
// types and constants of the led slot-pattern blinker
// no dependencies
package lspb_pkg;

	localparam int PIN_COUNT  = 4;
	localparam int CMD_W      = 3;
	localparam int LED_IDX_W  = 3;
	localparam int MASK_W     = 16;
	localparam int CNT_W      = 8;
	localparam int SLOT_W     = 4;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_BLINK = 2'd2
	} mode_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK       = 3'd0,
		CMD_OFF        = 3'd1,
		CMD_ON         = 3'd2,
		CMD_BLINK_DEF  = 3'd3,
		CMD_BLINK_MASK = 3'd4,
		CMD_TOGGLE     = 3'd5,
		CMD_QUERY      = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		REG_LED_PRESENT     = 2'd0,
		REG_HIGH_WHEN_ON    = 2'd1,
		REG_DEFAULT_PATTERN = 2'd2
	} reg_t;

	typedef struct packed {
		logic [CMD_W-1:0]     command;
		logic [LED_IDX_W-1:0] led_index;
		logic [MASK_W-1:0]    on_mask;
		logic [CNT_W-1:0]     slot_count;
	} item_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] pin_levels;
		logic                 status;
		logic [1:0]           mode_now;
		logic [SLOT_W-1:0]    slot_now;
	} result_t;

	typedef struct packed {
		logic [PIN_COUNT-1:0] led_present;
		logic [PIN_COUNT-1:0] high_when_on;
		logic [MASK_W-1:0]    default_pattern;
	} cfg_t;

endpackage

/* sv/lspb_cmd_if.sv */
// command channel of the led slot-pattern blinker
// depends on lspb_pkg
interface lspb_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [lspb_pkg::CMD_W-1:0]      command;
	logic [lspb_pkg::LED_IDX_W-1:0]  led_index;
	logic [lspb_pkg::MASK_W-1:0]     on_mask;
	logic [lspb_pkg::CNT_W-1:0]      slot_count;

	modport source (output valid, command, led_index, on_mask, slot_count, input ready);
	modport sink (input valid, command, led_index, on_mask, slot_count, output ready);
endinterface

/* sv/lspb_res_if.sv */
// result channel of the led slot-pattern blinker
// depends on lspb_pkg
interface lspb_res_if;
	logic                            valid;
	logic                            ready;
	logic [lspb_pkg::PIN_COUNT-1:0]  pin_levels;
	logic                            status;
	logic [1:0]                      mode_now;
	logic [lspb_pkg::SLOT_W-1:0]     slot_now;

	modport source (output valid, pin_levels, status, mode_now, slot_now, input ready);
	modport sink (input valid, pin_levels, status, mode_now, slot_now, output ready);
endinterface

/* sv/lspb_core.sv */
// led state, shared slot counter and single-pass command evaluation
// depends on lspb_pkg and led_slot_pattern_blinker_top_macros.svh
`include "led_slot_pattern_blinker_top_macros.svh"

module lspb_core #(
	parameter int LED_COUNT  = 4,
	parameter int SLOT_COUNT = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  lspb_pkg::item_t   item,
	input  lspb_pkg::cfg_t    cfg,
	output lspb_pkg::result_t result
);

	// only the first four leds can ever be fitted
	localparam int LEDS = (LED_COUNT < lspb_pkg::PIN_COUNT) ? LED_COUNT : lspb_pkg::PIN_COUNT;
	localparam int IDX_W = (LEDS > 1) ? $clog2(LEDS) : 1;
	localparam logic [lspb_pkg::SLOT_W-1:0] SLOT_LAST = lspb_pkg::SLOT_W'(SLOT_COUNT - 1);

	lspb_pkg::mode_t                 mode_q [LEDS];
	logic [lspb_pkg::MASK_W-1:0]     pat_q  [LEDS];
	logic [lspb_pkg::CNT_W-1:0]      left_q [LEDS];
	logic                            fore_q [LEDS];
	logic [lspb_pkg::SLOT_W-1:0]     slot_q;
	logic                            ticking_q;

	lspb_pkg::mode_t                 mode_d [LEDS];
	logic [lspb_pkg::MASK_W-1:0]     pat_d  [LEDS];
	logic [lspb_pkg::CNT_W-1:0]      left_d [LEDS];
	logic                            fore_d [LEDS];
	logic [lspb_pkg::SLOT_W-1:0]     slot_d;
	logic                            ticking_d;

	logic [IDX_W-1:0]                sel;
	logic                            in_range;
	logic                            fit;
	logic                            is_tick;
	logic                            req_write;
	lspb_pkg::mode_t                 req_mode;
	logic [lspb_pkg::MASK_W-1:0]     req_pat;
	logic [lspb_pkg::CNT_W-1:0]      req_left;
	logic                            req_fore;
	logic                            same;
	logic                            do_apply;
	logic                            do_tick;
	logic                            any_blink_d;
	logic                            any_blink_q;
	logic [lspb_pkg::PIN_COUNT-1:0]  levels;

	assign sel      = item.led_index[IDX_W-1:0];
	assign in_range = item.led_index < lspb_pkg::LED_IDX_W'(LEDS);
	assign fit      = in_range && cfg.led_present[sel];
	assign is_tick  = lspb_pkg::cmd_t'(item.command) == lspb_pkg::CMD_TICK;

	// requested setting for the addressed led
	always_comb begin
		req_write = 1'b0;
		req_mode  = lspb_pkg::MODE_OFF;
		req_pat   = '0;
		req_left  = '0;
		req_fore  = 1'b0;
		unique case (lspb_pkg::cmd_t'(item.command))
			lspb_pkg::CMD_OFF: begin
				req_write = 1'b1;
			end
			lspb_pkg::CMD_ON: begin
				req_write = 1'b1;
				req_mode  = lspb_pkg::MODE_ON;
			end
			lspb_pkg::CMD_BLINK_DEF: begin
				req_write = 1'b1;
				req_mode  = lspb_pkg::MODE_BLINK;
				req_pat   = cfg.default_pattern;
				req_fore  = 1'b1;
			end
			lspb_pkg::CMD_BLINK_MASK: begin
				req_write = 1'b1;
				req_mode  = lspb_pkg::MODE_BLINK;
				req_pat   = item.on_mask;
				req_left  = item.slot_count;
				req_fore  = item.slot_count == '0;
			end
			lspb_pkg::CMD_TOGGLE: begin
				req_write = 1'b1;
				req_mode  = (mode_q[sel] == lspb_pkg::MODE_OFF) ? lspb_pkg::MODE_ON
					: lspb_pkg::MODE_OFF;
			end
			default: begin
			end
		endcase
	end

	assign same = mode_q[sel] == req_mode && pat_q[sel] == req_pat
		&& left_q[sel] == req_left && fore_q[sel] == req_fore;
	assign do_apply = !is_tick && fit && req_write && !same;
	assign do_tick  = is_tick && ticking_q;

	always_comb begin
		mode_d    = mode_q;
		pat_d     = pat_q;
		left_d    = left_q;
		fore_d    = fore_q;
		slot_d    = slot_q;
		ticking_d = ticking_q;
		any_blink_d = 1'b0;
		if (do_tick) begin
			slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + lspb_pkg::SLOT_W'(1);
			for (int i = 0; i < LEDS; i++) begin
				// spend one slot of every finite, non-empty blink
				if (mode_q[i] == lspb_pkg::MODE_BLINK && pat_q[i] != '0 && !fore_q[i]
					&& left_q[i] != '0) begin
					left_d[i] = left_q[i] - lspb_pkg::CNT_W'(1);
					if (left_q[i] == lspb_pkg::CNT_W'(1)) begin
						mode_d[i] = lspb_pkg::MODE_OFF;
						pat_d[i]  = '0;
					end
				end
			end
		end
		if (do_apply) begin
			mode_d[sel] = req_mode;
			pat_d[sel]  = req_pat;
			left_d[sel] = req_left;
			fore_d[sel] = req_fore;
		end
		for (int i = 0; i < LEDS; i++) begin
			any_blink_d = any_blink_d | (mode_d[i] == lspb_pkg::MODE_BLINK);
		end
		// timer starts from slot zero on the first blinking led, stops when a command leaves none blinking
		if (do_apply) begin
			if (any_blink_d) begin
				if (!ticking_q) begin
					ticking_d = 1'b1;
					slot_d    = '0;
				end
			end else begin
				ticking_d = 1'b0;
			end
		end
	end

	for (genvar g = 0; g < lspb_pkg::PIN_COUNT; g++) begin : g_pin
		if (g < LEDS) begin : g_led
			logic lit;
			assign lit = (mode_d[g] == lspb_pkg::MODE_ON)
				|| (mode_d[g] == lspb_pkg::MODE_BLINK && pat_d[g][slot_d]);
			assign levels[g] = cfg.led_present[g]
				& (lit ? cfg.high_when_on[g] : ~cfg.high_when_on[g]);
		end else begin : g_none
			assign levels[g] = 1'b0;
		end
	end

	assign result.pin_levels = levels;
	assign result.status     = !is_tick && !fit;
	assign result.mode_now   = in_range ? mode_d[sel] : lspb_pkg::MODE_OFF;
	assign result.slot_now   = slot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LEDS; i++) begin
				mode_q[i] <= lspb_pkg::MODE_OFF;
				pat_q[i]  <= '0;
				left_q[i] <= '0;
				fore_q[i] <= 1'b0;
			end
			slot_q    <= '0;
			ticking_q <= 1'b0;
		end else if (fire) begin
			mode_q    <= mode_d;
			pat_q     <= pat_d;
			left_q    <= left_d;
			fore_q    <= fore_d;
			slot_q    <= slot_d;
			ticking_q <= ticking_d;
		end
	end

	always_comb begin
		any_blink_q = 1'b0;
		for (int i = 0; i < LEDS; i++) begin
			any_blink_q = any_blink_q | (mode_q[i] == lspb_pkg::MODE_BLINK);
		end
	end

	`LSPB_ASSERT_IMPL(a_blink_needs_timer, any_blink_q, ticking_q, "led blinking with timer stopped")
	`LSPB_ASSERT(a_slot_range, slot_q <= SLOT_LAST, "slot counter beyond last slot")
	`LSPB_ASSERT_NEXT(a_state_holds, !fire, $stable(slot_q) && $stable(ticking_q), "timer moved without a beat")
	for (genvar g = 0; g < LEDS; g++) begin : g_chk
		`LSPB_ASSERT_IMPL(a_idle_clear, mode_q[g] != lspb_pkg::MODE_BLINK, pat_q[g] == '0 && left_q[g] == '0 && !fore_q[g], "non-blinking led keeps blink data")
		`LSPB_ASSERT_IMPL(a_forever_no_count, fore_q[g], left_q[g] == '0, "endless blink with a slot count")
	end

endmodule

/* sv/led_slot_pattern_blinker_top.sv */
// a command beat is held in stage one, then its result beat in the result register
// throughput: one command per cycle when not stalled; one register stage in front of the
//   led state and one result register behind it, the state update being a single combinational pass
// a stalled result register holds the input stage, which then backs up the command channel
// reset (arst_n low, asynchronous): all leds off, timer stopped at slot 0, both stages empty,
//   led_present 0, high_when_on 15, default_pattern 255
// top level of the led slot-pattern blinker; depends on lspb_pkg, lspb_cmd_if, lspb_res_if, lspb_core
module led_slot_pattern_blinker_top #(
	parameter int LED_COUNT  = 4,
	parameter int SLOT_COUNT = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	lspb_cmd_if.sink                           cmd,
	lspb_res_if.source                         res,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [lspb_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [lspb_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [lspb_pkg::APB_DATA_W-1:0]    prdata,
	output logic                               pready
);

	// configuration registers
	logic [lspb_pkg::PIN_COUNT-1:0] led_present_q;
	logic [lspb_pkg::PIN_COUNT-1:0] high_when_on_q;
	logic [lspb_pkg::MASK_W-1:0]    default_pattern_q;
	lspb_pkg::cfg_t                 cfg;
	logic                           cfg_wr;
	lspb_pkg::reg_t                 reg_sel;

	// input stage and result register
	logic                           valid_s1;
	lspb_pkg::item_t                item_s1;
	logic                           adv_s1;
	logic                           res_valid_q;
	lspb_pkg::result_t              res_q;
	lspb_pkg::result_t              result;

	// apb: no wait states, register index from the word address
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_sel = lspb_pkg::reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_present_q     <= '0;
			high_when_on_q    <= '1;
			default_pattern_q <= lspb_pkg::MASK_W'(255);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				lspb_pkg::REG_LED_PRESENT:
					led_present_q <= pwdata[lspb_pkg::PIN_COUNT-1:0];
				lspb_pkg::REG_HIGH_WHEN_ON:
					high_when_on_q <= pwdata[lspb_pkg::PIN_COUNT-1:0];
				lspb_pkg::REG_DEFAULT_PATTERN:
					default_pattern_q <= pwdata[lspb_pkg::MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			lspb_pkg::REG_LED_PRESENT:
				prdata = lspb_pkg::APB_DATA_W'(led_present_q);
			lspb_pkg::REG_HIGH_WHEN_ON:
				prdata = lspb_pkg::APB_DATA_W'(high_when_on_q);
			lspb_pkg::REG_DEFAULT_PATTERN:
				prdata = lspb_pkg::APB_DATA_W'(default_pattern_q);
			default: begin
			end
		endcase
	end

	assign cfg.led_present     = led_present_q;
	assign cfg.high_when_on    = high_when_on_q;
	assign cfg.default_pattern = default_pattern_q;

	// the held command beat is evaluated and leaves stage one when the result register can take it
	assign adv_s1    = valid_s1 && (!res_valid_q || res.ready);
	assign cmd.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				valid_s1 <= cmd.valid;
			end
			if (adv_s1) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.command    <= cmd.command;
			item_s1.led_index  <= cmd.led_index;
			item_s1.on_mask    <= cmd.on_mask;
			item_s1.slot_count <= cmd.slot_count;
		end
		if (adv_s1) begin
			res_q <= result;
		end
	end

	// led state updates on the same edge the result is captured
	lspb_core #(
		.LED_COUNT  (LED_COUNT),
		.SLOT_COUNT (SLOT_COUNT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	assign res.valid      = res_valid_q;
	assign res.pin_levels = res_q.pin_levels;
	assign res.status     = res_q.status;
	assign res.mode_now   = res_q.mode_now;
	assign res.slot_now   = res_q.slot_now;

endmodule
